// ===== src/fccr_pkg.sv =====
package fccr_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = 13;
  localparam int ACC_W       = 34;
  localparam int CB_W        = 17;

  localparam logic [31:0] END_MARK     = 32'h0FFF_FFFF;
  localparam logic [27:0] LINK_LIMIT   = 28'h0FF_FFF0;
  localparam logic [CNT_W-1:0] FIRST_SEARCH = CNT_W'(3);

  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_RESIZE = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic REG_SPC  = 1'b0;
  localparam logic REG_FATN = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISPATCH, ST_RD_ISSUE, ST_RD_WAIT, ST_WR, ST_WALK_CHK, ST_WALK_DAT,
    ST_MARK_END, ST_TRIM_DAT, ST_FREE_RD, ST_FREE_DAT, ST_APP_CHK, ST_SCAN_RD,
    ST_SCAN_DAT, ST_APP_LINK, ST_DONE
  } state_t;

  typedef enum logic [1:0] {ASEL_IDX, ASEL_CUR, ASEL_SCAN} addr_sel_t;
  typedef enum logic [1:0] {WSEL_VAL, WSEL_END, WSEL_ZERO, WSEL_SCAN} wdata_sel_t;

  typedef struct packed {
    logic       load_in;
    logic       op_init;
    logic       walk_init;
    logic       walk_adv;
    logic       cur_link;
    logic       steps_clr;
    logic       steps_inc;
    logic       scan_init;
    logic       scan_inc;
    logic       first_found;
    logic       app_link;
    logic       set_err;
    logic       rd_load;
    logic       out_load;
    logic       mem_re;
    logic       mem_we;
    addr_sel_t  addr_sel;
    wdata_sel_t wdata_sel;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       len_zero;
    logic       start_valid;
    logic       acc_lt_len;
    logic       steps_lt_depth;
    logic       free_more;
    logic       rd_link;
    logic       rd_free;
    logic       scan_lt_lim;
    logic       count_zero;
    logic       out_busy;
  } stat_t;

  function automatic logic is_link(input logic [31:0] v);
    logic [27:0] m;
    m = v[27:0];
    return (m >= 28'd2) && (m < LINK_LIMIT) && (m < 28'(TABLE_DEPTH));
  endfunction

endpackage

// ===== src/fat_cluster_chain_resizer.sv =====
// Read entry: DISPATCH, RD_ISSUE, RD_WAIT, DONE; write entry: DISPATCH, WR, DONE.
// Resize: each cluster walked, freed or scanned in the free search takes a read
// state and a data state, as the single table RAM port has registered read data.
// One item in work at a time; the next item is taken while a result waits.
// rst_n (synchronous, active low) clears the FSM, out_tvalid and config registers;
// the datapath and table are not cleared; the table is undefined until written.
module fat_cluster_chain_resizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,  // entry_index, entry_value, chain_start, byte_length
  input  logic [1:0]  in_tuser,  // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata, // read_value, new_start, cluster_count, pad
  output logic        out_tuser, // status
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  fccr_pkg::cmd_t  cmd;
  fccr_pkg::stat_t st;
  logic [7:0]  spc_r;
  logic [12:0] fatn_r;
  logic        in_fire;

  assign cfg_pready = 1'b1;
  assign in_fire    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spc_r  <= 8'd8;
      fatn_r <= 13'd4096;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      if (cfg_paddr[2] == fccr_pkg::REG_SPC) spc_r <= cfg_pwdata[7:0];
      else                                    fatn_r <= cfg_pwdata[12:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == fccr_pkg::REG_FATN) ? {19'd0, fatn_r} : {24'd0, spc_r};

  fccr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .st        (st),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  fccr_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .st          (st),
    .in_op       (in_tuser),
    .in_idx      (in_tdata[11:0]),
    .in_val      (in_tdata[43:12]),
    .in_start    (in_tdata[55:44]),
    .in_len      (in_tdata[87:56]),
    .spc         (spc_r),
    .fat_entries (fatn_r),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

// ===== src/fccr_ram.sv =====
module fccr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     re,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== src/fccr_ctrl.sv =====
module fccr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_fire,
  input  fccr_pkg::stat_t st,
  output logic           in_tready,
  output fccr_pkg::cmd_t cmd
);

  fccr_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fccr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fccr_pkg::ST_IDLE: begin
        if (in_fire) state_nxt = fccr_pkg::ST_DISPATCH;
      end
      fccr_pkg::ST_DISPATCH: begin
        case (st.op)
          fccr_pkg::OP_READ:  state_nxt = fccr_pkg::ST_RD_ISSUE;
          fccr_pkg::OP_WRITE: state_nxt = fccr_pkg::ST_WR;
          fccr_pkg::OP_RESIZE: begin
            if (st.len_zero) begin
              state_nxt = st.start_valid ? fccr_pkg::ST_FREE_RD : fccr_pkg::ST_DONE;
            end else begin
              state_nxt = st.start_valid ? fccr_pkg::ST_WALK_CHK : fccr_pkg::ST_APP_CHK;
            end
          end
          default: state_nxt = fccr_pkg::ST_DONE;
        endcase
      end
      fccr_pkg::ST_RD_ISSUE: state_nxt = fccr_pkg::ST_RD_WAIT;
      fccr_pkg::ST_RD_WAIT:  state_nxt = fccr_pkg::ST_DONE;
      fccr_pkg::ST_WR:       state_nxt = fccr_pkg::ST_DONE;
      fccr_pkg::ST_WALK_CHK: begin
        if (st.acc_lt_len && st.steps_lt_depth) state_nxt = fccr_pkg::ST_WALK_DAT;
        else if (!st.acc_lt_len)                state_nxt = fccr_pkg::ST_TRIM_DAT;
        else                                    state_nxt = fccr_pkg::ST_MARK_END;
      end
      fccr_pkg::ST_WALK_DAT: begin
        state_nxt = st.rd_link ? fccr_pkg::ST_WALK_CHK : fccr_pkg::ST_MARK_END;
      end
      fccr_pkg::ST_MARK_END: state_nxt = fccr_pkg::ST_APP_CHK;
      fccr_pkg::ST_TRIM_DAT: begin
        state_nxt = st.rd_link ? fccr_pkg::ST_FREE_RD : fccr_pkg::ST_DONE;
      end
      fccr_pkg::ST_FREE_RD: state_nxt = fccr_pkg::ST_FREE_DAT;
      fccr_pkg::ST_FREE_DAT: begin
        state_nxt = (st.rd_link && st.free_more) ? fccr_pkg::ST_FREE_RD : fccr_pkg::ST_DONE;
      end
      fccr_pkg::ST_APP_CHK: begin
        state_nxt = st.acc_lt_len ? fccr_pkg::ST_SCAN_RD : fccr_pkg::ST_DONE;
      end
      fccr_pkg::ST_SCAN_RD: begin
        state_nxt = st.scan_lt_lim ? fccr_pkg::ST_SCAN_DAT : fccr_pkg::ST_DONE;
      end
      fccr_pkg::ST_SCAN_DAT: begin
        if (!st.rd_free)        state_nxt = fccr_pkg::ST_SCAN_RD;
        else if (st.count_zero) state_nxt = fccr_pkg::ST_APP_CHK;
        else                    state_nxt = fccr_pkg::ST_APP_LINK;
      end
      fccr_pkg::ST_APP_LINK: state_nxt = fccr_pkg::ST_APP_CHK;
      fccr_pkg::ST_DONE: begin
        if (!st.out_busy) state_nxt = fccr_pkg::ST_IDLE;
      end
      default: state_nxt = fccr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      fccr_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_fire;
      end
      fccr_pkg::ST_DISPATCH: begin
        cmd.op_init   = 1'b1;
        cmd.walk_init = (st.op == fccr_pkg::OP_RESIZE) && !st.len_zero && st.start_valid;
      end
      fccr_pkg::ST_RD_ISSUE: begin
        cmd.mem_re   = 1'b1;
        cmd.addr_sel = fccr_pkg::ASEL_IDX;
      end
      fccr_pkg::ST_RD_WAIT: cmd.rd_load = 1'b1;
      fccr_pkg::ST_WR: begin
        cmd.mem_we    = 1'b1;
        cmd.addr_sel  = fccr_pkg::ASEL_IDX;
        cmd.wdata_sel = fccr_pkg::WSEL_VAL;
      end
      fccr_pkg::ST_WALK_CHK, fccr_pkg::ST_FREE_RD: begin
        cmd.mem_re   = 1'b1;
        cmd.addr_sel = fccr_pkg::ASEL_CUR;
      end
      fccr_pkg::ST_WALK_DAT: cmd.walk_adv = st.rd_link;
      fccr_pkg::ST_MARK_END: begin
        cmd.mem_we    = 1'b1;
        cmd.addr_sel  = fccr_pkg::ASEL_CUR;
        cmd.wdata_sel = fccr_pkg::WSEL_END;
      end
      fccr_pkg::ST_TRIM_DAT: begin
        cmd.mem_we    = 1'b1;
        cmd.addr_sel  = fccr_pkg::ASEL_CUR;
        cmd.wdata_sel = fccr_pkg::WSEL_END;
        cmd.cur_link  = st.rd_link;
        cmd.steps_clr = 1'b1;
      end
      fccr_pkg::ST_FREE_DAT: begin
        cmd.mem_we    = 1'b1;
        cmd.addr_sel  = fccr_pkg::ASEL_CUR;
        cmd.wdata_sel = fccr_pkg::WSEL_ZERO;
        cmd.steps_inc = 1'b1;
        cmd.cur_link  = st.rd_link;
      end
      fccr_pkg::ST_APP_CHK: cmd.scan_init = st.acc_lt_len;
      fccr_pkg::ST_SCAN_RD: begin
        cmd.mem_re   = st.scan_lt_lim;
        cmd.addr_sel = fccr_pkg::ASEL_SCAN;
        cmd.set_err  = !st.scan_lt_lim;
      end
      fccr_pkg::ST_SCAN_DAT: begin
        if (!st.rd_free) begin
          cmd.scan_inc = 1'b1;
        end else if (st.count_zero) begin
          cmd.mem_we      = 1'b1;
          cmd.addr_sel    = fccr_pkg::ASEL_SCAN;
          cmd.wdata_sel   = fccr_pkg::WSEL_END;
          cmd.first_found = 1'b1;
        end else begin
          cmd.mem_we    = 1'b1;
          cmd.addr_sel  = fccr_pkg::ASEL_CUR;
          cmd.wdata_sel = fccr_pkg::WSEL_SCAN;
        end
      end
      fccr_pkg::ST_APP_LINK: begin
        cmd.mem_we    = 1'b1;
        cmd.addr_sel  = fccr_pkg::ASEL_SCAN;
        cmd.wdata_sel = fccr_pkg::WSEL_END;
        cmd.app_link  = 1'b1;
      end
      fccr_pkg::ST_DONE: cmd.out_load = !st.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== src/fccr_dpath.sv =====
module fccr_dpath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fccr_pkg::cmd_t               cmd,
  output fccr_pkg::stat_t              st,
  input  logic [1:0]                   in_op,
  input  logic [fccr_pkg::ADDR_W-1:0]  in_idx,
  input  logic [31:0]                  in_val,
  input  logic [fccr_pkg::ADDR_W-1:0]  in_start,
  input  logic [31:0]                  in_len,
  input  logic [7:0]                   spc,
  input  logic [fccr_pkg::CNT_W-1:0]   fat_entries,
  input  logic                         out_tready,
  output logic                         out_tvalid,
  output logic [63:0]                  out_tdata,
  output logic                         out_tuser
);

  localparam int AW = fccr_pkg::ADDR_W;
  localparam int CW = fccr_pkg::CNT_W;

  logic [1:0]    op_r;
  logic [AW-1:0] idx_r, start_r, nstart_r, cur_r;
  logic [31:0]   val_r, len_r, rd_r, rdata, wdata;
  logic [CW-1:0] count_r, steps_r, scan_r, from_r, lim;
  logic [fccr_pkg::ACC_W-1:0] acc_r;
  logic [fccr_pkg::CB_W-1:0]  cb;
  logic          err_r, out_valid_r, rd_is_link;
  logic [AW-1:0] addr;
  logic [31:0]   o_rd_r;
  logic [AW-1:0] o_ns_r;
  logic [CW-1:0] o_cnt_r;
  logic          o_st_r;

  assign cb  = {((spc == 8'd0) ? 8'd1 : spc), 9'd0};
  assign lim = (fat_entries > CW'(fccr_pkg::TABLE_DEPTH)) ? CW'(fccr_pkg::TABLE_DEPTH)
                                                          : fat_entries;
  assign rd_is_link = fccr_pkg::is_link(rdata);

  always_comb begin
    case (cmd.addr_sel)
      fccr_pkg::ASEL_IDX:  addr = idx_r;
      fccr_pkg::ASEL_CUR:  addr = cur_r;
      fccr_pkg::ASEL_SCAN: addr = scan_r[AW-1:0];
      default:             addr = cur_r;
    endcase
    case (cmd.wdata_sel)
      fccr_pkg::WSEL_VAL:  wdata = val_r;
      fccr_pkg::WSEL_END:  wdata = fccr_pkg::END_MARK;
      fccr_pkg::WSEL_ZERO: wdata = 32'd0;
      fccr_pkg::WSEL_SCAN: wdata = 32'(scan_r);
      default:             wdata = 32'd0;
    endcase
  end

  fccr_ram #(.WIDTH(32), .DEPTH(fccr_pkg::TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .re    (cmd.mem_re),
    .we    (cmd.mem_we),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r    <= in_op;
      idx_r   <= in_idx;
      val_r   <= in_val;
      start_r <= in_start;
      len_r   <= in_len;
    end
    if (cmd.op_init) begin
      rd_r     <= '0;
      nstart_r <= '0;
      count_r  <= '0;
      acc_r    <= '0;
      err_r    <= 1'b0;
      from_r   <= fccr_pkg::FIRST_SEARCH;
      steps_r  <= '0;
      cur_r    <= start_r;
    end
    if (cmd.walk_init) begin
      nstart_r <= start_r;
      count_r  <= CW'(1);
      acc_r    <= fccr_pkg::ACC_W'(cb);
    end
    if (cmd.walk_adv) begin
      cur_r   <= rdata[AW-1:0];
      count_r <= count_r + CW'(1);
      acc_r   <= acc_r + fccr_pkg::ACC_W'(cb);
      steps_r <= steps_r + CW'(1);
    end
    if (cmd.cur_link) cur_r <= rdata[AW-1:0];
    if (cmd.steps_clr) steps_r <= '0;
    if (cmd.steps_inc) steps_r <= steps_r + CW'(1);
    if (cmd.scan_init) scan_r <= from_r;
    if (cmd.scan_inc) scan_r <= scan_r + CW'(1);
    if (cmd.first_found) begin
      cur_r    <= scan_r[AW-1:0];
      nstart_r <= scan_r[AW-1:0];
      count_r  <= CW'(1);
      acc_r    <= fccr_pkg::ACC_W'(cb);
    end
    if (cmd.app_link) begin
      cur_r   <= scan_r[AW-1:0];
      from_r  <= scan_r + CW'(1);
      count_r <= count_r + CW'(1);
      acc_r   <= acc_r + fccr_pkg::ACC_W'(cb);
    end
    if (cmd.set_err) err_r <= 1'b1;
    if (cmd.rd_load) rd_r <= rdata;
    if (cmd.out_load) begin
      o_rd_r  <= rd_r;
      o_ns_r  <= nstart_r;
      o_cnt_r <= count_r;
      o_st_r  <= err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, o_cnt_r, o_ns_r, o_rd_r};
  assign out_tuser  = o_st_r;

  assign st.op             = op_r;
  assign st.len_zero       = (len_r == 32'd0);
  assign st.start_valid    = (start_r >= AW'(2));
  assign st.acc_lt_len     = (acc_r < fccr_pkg::ACC_W'(len_r));
  assign st.steps_lt_depth = (steps_r < CW'(fccr_pkg::TABLE_DEPTH));
  assign st.free_more      = (steps_r < CW'(fccr_pkg::TABLE_DEPTH - 1));
  assign st.rd_link        = rd_is_link;
  assign st.rd_free        = (rdata[27:0] == 28'd0);
  assign st.scan_lt_lim    = (scan_r < lim);
  assign st.count_zero     = (count_r == '0);
  assign st.out_busy       = out_valid_r && !out_tready;

endmodule

// ===== src/fccr_checker.sv =====
module fccr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_start_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[43:32] == 12'd0) == (out_tdata[56:44] == 13'd0)))
    else $error("new_start and cluster_count disagree on empty chain");

  a_err_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata[31:0] == 32'd0))
    else $error("error flagged with read data");

endmodule

bind fat_cluster_chain_resizer fccr_checker u_fccr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
